@@ rtl/sfr_pkg.sv @@
// shared constants, register codes and helpers for the stream find-and-replace block
`default_nettype none

package sfr_pkg;

    // default window depth
    localparam int MAX_PATTERN_DEF = 8;
    // hard cap on pattern and replacement bytes set by the register format
    localparam int BYTE_LIMIT      = 8;
    localparam int LEN_W           = 4;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 64;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_BYTES      = 2'd0,
        REG_PATTERN_LENGTH     = 2'd1,
        REG_REPLACEMENT_BYTES  = 2'd2,
        REG_REPLACEMENT_LENGTH = 2'd3
    } t_cfg_reg;

    // pattern length write seen by the matcher
    typedef struct packed {
        logic             wr;
        logic [LEN_W-1:0] len;
    } t_len_upd;

    // effective length: zero counts as one, saturate at the window limit
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw,
                                                 input logic [LEN_W-1:0] limit);
        logic [LEN_W-1:0] v;
        v = (raw == '0) ? LEN_W'(1) : raw;
        if (v > limit) begin
            v = limit;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/sfr_in_if.sv @@
// input channel: one text byte per request
`default_nettype none

interface sfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/sfr_out_if.sv @@
// output channel: one rewritten byte per request
`default_nettype none

interface sfr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_done;

    modport source (output valid, output out_byte, output run_last, output stream_done,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input stream_done,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/stream_find_replace_core.sv @@
// top level of the streaming find-and-replace block
`default_nettype none

// Streaming find-and-replace. Each text byte goes into a window of pending bytes;
// when the window holds as many bytes as the pattern it is compared with it. A match
// sends the replacement and empties the window, a miss on a full window sends the
// oldest byte, and a byte marked final flushes the window. Results leave through a
// burst register one byte per cycle while the output is ready, so plain text, whose
// requests cause zero or one result, streams at one byte per clock; a request that
// causes more results holds the input until the last byte of its burst leaves. The user
// must write configuration only while the block is idle; the block does not enforce it.
module stream_find_replace_core #(
    parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [sfr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [sfr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    sfr_in_if.sink                                i_in,
    sfr_out_if.source                             o_out
);

    localparam int WIN = (MAX_PATTERN < sfr_pkg::BYTE_LIMIT) ? MAX_PATTERN
                                                             : sfr_pkg::BYTE_LIMIT;
    localparam int CW  = $clog2(WIN + 1);
    localparam int IW  = (WIN > 1) ? $clog2(WIN) : 1;

    logic [63:0]               r_pat_bytes;
    logic [sfr_pkg::LEN_W-1:0] r_pat_len;
    logic [63:0]               r_rep_bytes;
    logic [sfr_pkg::LEN_W-1:0] r_rep_len;

    logic [CW-1:0]             plen;
    logic [CW-1:0]             rlen;
    sfr_pkg::t_len_upd         len_upd;
    logic                      take;
    logic                      em_ready;
    logic [WIN-1:0][7:0]       burst_bytes;
    logic [CW-1:0]             burst_num;
    logic                      burst_fin;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_bytes <= '0;
            r_pat_len   <= sfr_pkg::LEN_W'(1);
            r_rep_bytes <= '0;
            r_rep_len   <= sfr_pkg::LEN_W'(1);
        end else if (i_cfg_wr_en) begin
            case (sfr_pkg::t_cfg_reg'(i_cfg_index))
                sfr_pkg::REG_PATTERN_BYTES: begin
                    r_pat_bytes <= i_cfg_data[63:0];
                end
                sfr_pkg::REG_PATTERN_LENGTH: begin
                    r_pat_len <= i_cfg_data[sfr_pkg::LEN_W-1:0];
                end
                sfr_pkg::REG_REPLACEMENT_BYTES: begin
                    r_rep_bytes <= i_cfg_data[63:0];
                end
                sfr_pkg::REG_REPLACEMENT_LENGTH: begin
                    r_rep_len <= i_cfg_data[sfr_pkg::LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // effective lengths
    assign plen = CW'(sfr_pkg::eff_len(r_pat_len, sfr_pkg::LEN_W'(WIN)));
    assign rlen = CW'(sfr_pkg::eff_len(r_rep_len, sfr_pkg::LEN_W'(WIN)));

    // pattern length write for the window clear
    assign len_upd.wr  = i_cfg_wr_en &&
                         (sfr_pkg::t_cfg_reg'(i_cfg_index) == sfr_pkg::REG_PATTERN_LENGTH);
    assign len_upd.len = i_cfg_data[sfr_pkg::LEN_W-1:0];

    // input handshake
    assign i_in.ready = em_ready;
    assign take       = i_in.valid && em_ready;

    sfr_matcher #(
        .WIN (WIN),
        .CW  (CW),
        .IW  (IW)
    ) u_matcher (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_data_byte   (i_in.data_byte),
        .i_final_byte  (i_in.final_byte),
        .i_plen        (plen),
        .i_rlen        (rlen),
        .i_pat_bytes   (r_pat_bytes),
        .i_rep_bytes   (r_rep_bytes),
        .i_len_upd     (len_upd),
        .o_burst_bytes (burst_bytes),
        .o_burst_num   (burst_num),
        .o_burst_fin   (burst_fin)
    );

    sfr_emitter #(
        .WIN (WIN),
        .CW  (CW)
    ) u_emitter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take),
        .i_bytes (burst_bytes),
        .i_num   (burst_num),
        .i_fin   (burst_fin),
        .o_ready (em_ready),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

@@ rtl/sfr_matcher.sv @@
// pending window, pattern compare and burst build for one input byte
`default_nettype none

module sfr_matcher #(
    parameter int WIN = sfr_pkg::BYTE_LIMIT,
    parameter int CW  = $clog2(WIN + 1),
    parameter int IW  = (WIN > 1) ? $clog2(WIN) : 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_take,
    input  wire logic [7:0]          i_data_byte,
    input  wire logic                i_final_byte,
    input  wire logic [CW-1:0]       i_plen,
    input  wire logic [CW-1:0]       i_rlen,
    input  wire logic [63:0]         i_pat_bytes,
    input  wire logic [63:0]         i_rep_bytes,
    input  wire sfr_pkg::t_len_upd   i_len_upd,
    output logic [WIN-1:0][7:0]      o_burst_bytes,
    output logic [CW-1:0]            o_burst_num,
    output logic                     o_burst_fin
);

    logic [WIN-1:0][7:0] r_window;
    logic [WIN-1:0][7:0] n_window;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;

    logic [WIN-1:0][7:0] w;
    logic [CW-1:0]       c0;
    logic [CW-1:0]       cnt1;
    logic                full;
    logic                match;
    logic [CW-1:0]       upd_plen;

    // window with the new byte placed at the fill position
    always_comb begin
        c0 = (r_count >= i_plen) ? '0 : r_count;
        w  = r_window;
        w[c0[IW-1:0]] = i_data_byte;
        cnt1 = c0 + CW'(1);
        full = (cnt1 == i_plen);
    end

    // compare the full window with the pattern
    always_comb begin
        match = full;
        for (int i = 0; i < WIN; i++) begin
            if ((CW'(i) < i_plen) && (w[i] != i_pat_bytes[8*i +: 8])) begin
                match = 1'b0;
            end
        end
    end

    // burst contents and next window state
    always_comb begin
        o_burst_fin = i_final_byte;
        n_window    = w;
        if (match) begin
            for (int i = 0; i < WIN; i++) begin
                o_burst_bytes[i] = i_rep_bytes[8*i +: 8];
            end
            o_burst_num = i_rlen;
            n_count     = '0;
        end else if (i_final_byte) begin
            o_burst_bytes = w;
            o_burst_num   = cnt1;
            n_count       = '0;
        end else if (full) begin
            o_burst_bytes = w;
            o_burst_num   = CW'(1);
            for (int i = 0; i < WIN - 1; i++) begin
                n_window[i] = w[i+1];
            end
            n_count = cnt1 - CW'(1);
        end else begin
            o_burst_bytes = w;
            o_burst_num   = '0;
            n_count       = cnt1;
        end
    end

    // shrinking the pattern to the fill level or below drops the pending bytes
    assign upd_plen = CW'(sfr_pkg::eff_len(i_len_upd.len, sfr_pkg::LEN_W'(WIN)));

    // window and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_take) begin
            r_count <= n_count;
        end else if (i_len_upd.wr && (r_count >= upd_plen)) begin
            r_count <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_window <= n_window;
        end
    end

endmodule

`default_nettype wire

@@ rtl/sfr_emitter.sv @@
// result register that plays a burst out one byte per request
`default_nettype none

module sfr_emitter #(
    parameter int WIN = sfr_pkg::BYTE_LIMIT,
    parameter int CW  = $clog2(WIN + 1)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire logic [WIN-1:0][7:0] i_bytes,
    input  wire logic [CW-1:0]       i_num,
    input  wire logic                i_fin,
    output logic                     o_ready,
    sfr_out_if.source                o_out
);

    logic [WIN-1:0][7:0] r_bytes;
    logic [CW-1:0]       r_left;
    logic                r_fin;
    logic                last;
    logic                take;

    assign last    = (r_left == CW'(1));
    assign take    = o_out.valid && o_out.ready;
    // free once the burst is gone or its last byte leaves now
    assign o_ready = (r_left == '0) || (last && o_out.ready);

    // output side
    assign o_out.valid       = (r_left != '0);
    assign o_out.out_byte    = r_bytes[0];
    assign o_out.run_last    = last;
    assign o_out.stream_done = last && r_fin;

    // remaining byte count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_load) begin
            r_left <= i_num;
        end else if (take) begin
            r_left <= r_left - CW'(1);
        end
    end

    // burst bytes shift toward the output slot
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_bytes;
            r_fin   <= i_fin;
        end else if (take) begin
            for (int i = 0; i < WIN - 1; i++) begin
                r_bytes[i] <= r_bytes[i+1];
            end
        end
    end

endmodule

`default_nettype wire
